### hdl/mti_pkg.sv
`timescale 1ns / 1ps
package mti_pkg;

   localparam int MaxInputs = 4;
   localparam int MaxDegree = 3;
   localparam int MaxNodes  = 64;
   localparam int FracBits  = 16;
   localparam int MaxCount  = 7;

   localparam int FeatCap = (MaxDegree <= 1) ? MaxInputs :
      (MaxDegree == 2) ? ((MaxInputs + 2) * (MaxInputs + 1)) / 2 - 1 :
      (MaxDegree == 3) ? ((MaxInputs + 3) * (MaxInputs + 2) * (MaxInputs + 1)) / 6 - 1 :
      ((MaxInputs + 4) * (MaxInputs + 3) * (MaxInputs + 2) * (MaxInputs + 1)) / 24 - 1;
   localparam int Slots = FeatCap + 1;

   localparam int NodeW   = 7;
   localparam int NodeAw  = $clog2(MaxNodes);
   localparam int SlotW   = 6;
   localparam int FeatAw  = $clog2(Slots);
   localparam int CoefAw  = $clog2(MaxNodes * Slots);
   localparam int RawAw   = $clog2(MaxInputs);
   localparam int CountW  = 3;
   localparam int DegW    = 2;
   localparam int RndW    = 64 - FracBits;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      KIND_HDR  = 2'd0,
      KIND_COEF = 2'd1,
      KIND_FEAT = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_COUNT = 2'd1,
      ERR_WALK  = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      CSR_OBLIQUE = 2'd0,
      CSR_DEGREE  = 2'd1,
      CSR_INTER   = 2'd2,
      CSR_COUNT   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_HDR  = 2'd0,
      OP_COEF = 2'd1,
      OP_FEAT = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [6:0]         node_index;
      logic               leaf_flag;
      logic [6:0]         first_child;
      logic [6:0]         second_child;
      logic [5:0]         coef_slot;
      logic signed [31:0] coef_value;
      logic signed [31:0] feature_value;
      logic               last_feature;
   } req_type;

   typedef struct packed {
      logic signed [31:0] prediction;
      logic [6:0]         leaf_node;
      logic [1:0]         error_code;
   } rsp_type;

   typedef struct packed {
      logic              oblique_splits;
      logic [DegW-1:0]   poly_degree;
      logic              distinct_only;
      logic [CountW-1:0] input_count;
   } cfg_type;

   typedef struct packed {
      op_type             op;
      logic [NodeAw-1:0]  node_addr;
      logic               leaf;
      logic [NodeW-1:0]   child0;
      logic [NodeW-1:0]   child1;
      logic [SlotW-1:0]   slot;
      logic signed [31:0] value;
      logic               last;
   } cmd_type;

   function automatic logic signed [RndW-1:0] rnd_prod(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
      return t[RndW-1:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

### hdl/mti_front.sv
`timescale 1ns / 1ps
module mti_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mti_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_ready,
   output mti_pkg::cmd_type q_cmd
);
   import mti_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   cmd_type         queue_ff [QueueDepth];
   logic [PtrW-1:0] wptr_ff;
   logic [PtrW-1:0] rptr_ff;
   logic [PtrW:0]   count_ff;
   cmd_type         cmd;
   logic            keep;
   logic            node_ok;
   logic            push;
   logic            pop;

   assign node_ok = (req_data.node_index >= NodeW'(1)) &&
                    (req_data.node_index <= NodeW'(MaxNodes));

   always_comb begin
      cmd.node_addr = NodeAw'(req_data.node_index - NodeW'(1));
      cmd.leaf      = req_data.leaf_flag;
      cmd.child0    = req_data.first_child;
      cmd.child1    = req_data.second_child;
      cmd.slot      = req_data.coef_slot;
      cmd.last      = req_data.last_feature;
      cmd.op        = OP_FEAT;
      cmd.value     = req_data.feature_value;
      keep          = 1'b0;
      case (kind_type'(req_data.kind))
         KIND_HDR: begin
            cmd.op = OP_HDR;
            keep   = node_ok;
         end
         KIND_COEF: begin
            cmd.op    = OP_COEF;
            cmd.value = req_data.coef_value;
            keep      = node_ok && (req_data.coef_slot < SlotW'(Slots));
         end
         KIND_FEAT: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = (count_ff < (PtrW + 1)'(QueueDepth));
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_valid && q_ready;
   assign q_cmd     = queue_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= (wptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wptr_ff + PtrW'(1);
         end
         if (pop) begin
            rptr_ff <= (rptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rptr_ff + PtrW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (PtrW + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (PtrW + 1)'(1);
         end
      end
   end

endmodule

### hdl/mti_back.sv
`timescale 1ns / 1ps
module mti_back (
   input  logic             clock,
   input  logic             reset,
   input  mti_pkg::cfg_type cfg,
   input  logic             q_valid,
   output logic             q_ready,
   input  mti_pkg::cmd_type q_cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mti_pkg::rsp_type rsp_data
);
   import mti_pkg::*;

   typedef struct packed {
      logic             leaf;
      logic [NodeW-1:0] child0;
      logic [NodeW-1:0] child1;
   } hdr_type;

   typedef enum logic [4:0] {
      S_IDLE, S_COPY, S_DLOOP, S_ILOOP, S_KLOOP, S_KMUL, S_KWR,
      S_WCHK, S_HDR, S_BRD, S_BLD, S_DRD, S_DMUL, S_DACC, S_DEND,
      S_SRD0, S_SIX, S_SRD1, S_SCMP, S_OUT
   } state_type;

   state_type          state_ff;
   hdr_type            hdr_mem [MaxNodes];
   logic signed [31:0] coef_mem [MaxNodes * Slots];
   logic signed [31:0] exp_mem [FeatCap];
   hdr_type            hdr_rd_ff;
   logic signed [31:0] coef_rd_ff;
   logic signed [31:0] exp_rd_ff;

   logic signed [31:0] raw_ff [MaxInputs];
   logic [CountW-1:0]  cnt_ff;
   logic [CountW-1:0]  n_ff;
   logic [DegW-1:0]    deg_ff;
   logic               inter_ff;
   logic [FeatAw-1:0]  total_ff;
   logic [CountW-1:0]  i_ff;
   logic [FeatAw-1:0]  k_ff;
   logic [DegW-1:0]    d_ff;
   logic [FeatAw-1:0]  idx_ff [MaxInputs];
   logic [FeatAw-1:0]  prev_start_ff;
   logic [FeatAw-1:0]  prev_len_ff;
   logic [FeatAw-1:0]  new_start_ff;
   logic [FeatAw-1:0]  new_len_ff;
   logic [FeatAw-1:0]  nxt_ff;
   logic [NodeW-1:0]   cur_ff;
   logic [NodeW-1:0]   steps_ff;
   logic [CoefAw-1:0]  base_ff;
   logic [FeatAw-1:0]  j_ff;
   logic [FeatAw-1:0]  fidx_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] prod_ff;
   hdr_type            hdr_ff;
   rsp_type            res_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic               hdr_we;
   logic               coef_we;
   logic [CoefAw-1:0]  coef_waddr;
   logic [CoefAw-1:0]  coef_raddr;
   logic               exp_we;
   logic [FeatAw-1:0]  exp_waddr;
   logic signed [31:0] exp_wdata;
   logic [FeatAw-1:0]  exp_raddr;
   logic [NodeAw-1:0]  hdr_raddr;
   logic signed [RndW-1:0] rnd;
   logic [CountW-1:0]  cnt_next;
   logic [CountW-1:0]  lim;
   logic [DegW-1:0]    deg0;
   logic [CountW-1:0]  deg_clamped;
   logic [32:0]        mag;
   logic [16:0]        quo;
   logic               fi_ok;
   logic               pop;

   assign q_ready   = (state_ff == S_IDLE);
   assign pop       = q_valid && q_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rnd       = rnd_prod(prod_ff);
   assign cnt_next  = (cnt_ff < CountW'(MaxCount)) ? cnt_ff + CountW'(1) : cnt_ff;
   assign lim       = n_ff - (inter_ff ? CountW'(d_ff) : CountW'(0));
   assign deg0      = (cfg.poly_degree == '0) ? DegW'(1) : cfg.poly_degree;
   assign deg_clamped = (cfg.distinct_only && (CountW'(deg0) > cfg.input_count)) ?
                        cfg.input_count : CountW'(deg0);
   assign mag       = coef_rd_ff[31] ? -{coef_rd_ff[31], coef_rd_ff} :
                                       {coef_rd_ff[31], coef_rd_ff};
   assign quo       = mag[32:FracBits];
   assign fi_ok     = (quo == '0) || (!coef_rd_ff[31] && (quo < 17'(total_ff)));

   always_comb begin
      hdr_we     = pop && (q_cmd.op == OP_HDR);
      coef_we    = pop && (q_cmd.op == OP_COEF);
      coef_waddr = CoefAw'(CoefAw'(q_cmd.node_addr) * CoefAw'(Slots) + CoefAw'(q_cmd.slot));
      hdr_raddr  = NodeAw'(cur_ff - NodeW'(1));
      exp_we     = 1'b0;
      exp_waddr  = total_ff;
      exp_wdata  = sat32({{(64 - RndW){rnd[RndW-1]}}, rnd});
      exp_raddr  = j_ff;
      coef_raddr = CoefAw'(base_ff + CoefAw'(j_ff));
      case (state_ff)
         S_COPY: begin
            exp_we    = 1'b1;
            exp_waddr = FeatAw'(i_ff);
            exp_wdata = raw_ff[i_ff[RawAw-1:0]];
         end
         S_KLOOP: begin
            exp_raddr = FeatAw'(prev_start_ff + k_ff);
         end
         S_KWR: begin
            exp_we = 1'b1;
         end
         S_BRD: begin
            coef_raddr = CoefAw'(base_ff + CoefAw'(total_ff));
         end
         S_SRD0: begin
            coef_raddr = base_ff;
         end
         S_SRD1: begin
            coef_raddr = CoefAw'(base_ff + CoefAw'(1));
            exp_raddr  = fidx_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_mem[q_cmd.node_addr] <= '{q_cmd.leaf, q_cmd.child0, q_cmd.child1};
      end
      hdr_rd_ff <= hdr_mem[hdr_raddr];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= q_cmd.value;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (exp_we) begin
         exp_mem[exp_waddr] <= exp_wdata;
      end
      exp_rd_ff <= exp_mem[exp_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < MaxInputs; r++) begin
            raw_ff[r] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop && (q_cmd.op == OP_FEAT)) begin
                  if (cnt_ff < CountW'(MaxInputs)) begin
                     raw_ff[cnt_ff[RawAw-1:0]] <= q_cmd.value;
                  end
                  if (q_cmd.last) begin
                     cnt_ff <= '0;
                     if ((cfg.input_count == '0) ||
                         (cfg.input_count > CountW'(MaxInputs)) ||
                         (cnt_next != cfg.input_count)) begin
                        res_ff   <= '{32'sd0, NodeW'(0), ERR_COUNT};
                        state_ff <= S_OUT;
                     end else begin
                        n_ff     <= cfg.input_count;
                        deg_ff   <= DegW'(deg_clamped);
                        inter_ff <= cfg.distinct_only;
                        i_ff     <= '0;
                        state_ff <= S_COPY;
                     end
                  end else begin
                     cnt_ff <= cnt_next;
                  end
               end
            end
            S_COPY: begin
               idx_ff[i_ff[RawAw-1:0]] <= FeatAw'(i_ff);
               i_ff <= i_ff + CountW'(1);
               if (i_ff == n_ff - CountW'(1)) begin
                  total_ff      <= FeatAw'(n_ff);
                  prev_start_ff <= '0;
                  prev_len_ff   <= FeatAw'(n_ff);
                  d_ff          <= DegW'(1);
                  state_ff      <= S_DLOOP;
               end
            end
            S_DLOOP: begin
               if (d_ff >= deg_ff) begin
                  cur_ff   <= NodeW'(1);
                  steps_ff <= '0;
                  state_ff <= S_WCHK;
               end else begin
                  new_start_ff <= total_ff;
                  new_len_ff   <= '0;
                  i_ff         <= '0;
                  state_ff     <= S_ILOOP;
               end
            end
            S_ILOOP: begin
               if (i_ff >= lim) begin
                  prev_start_ff <= new_start_ff;
                  prev_len_ff   <= new_len_ff;
                  d_ff          <= d_ff + DegW'(1);
                  state_ff      <= S_DLOOP;
               end else begin
                  nxt_ff   <= new_len_ff;
                  k_ff     <= idx_ff[RawAw'(i_ff + (inter_ff ? CountW'(1) : CountW'(0)))];
                  state_ff <= S_KLOOP;
               end
            end
            S_KLOOP: begin
               if ((k_ff < prev_len_ff) && (total_ff < FeatAw'(FeatCap))) begin
                  state_ff <= S_KMUL;
               end else begin
                  idx_ff[i_ff[RawAw-1:0]] <= nxt_ff;
                  i_ff     <= i_ff + CountW'(1);
                  state_ff <= S_ILOOP;
               end
            end
            S_KMUL: begin
               prod_ff  <= raw_ff[i_ff[RawAw-1:0]] * exp_rd_ff;
               state_ff <= S_KWR;
            end
            S_KWR: begin
               total_ff   <= total_ff + FeatAw'(1);
               new_len_ff <= new_len_ff + FeatAw'(1);
               k_ff       <= k_ff + FeatAw'(1);
               state_ff   <= S_KLOOP;
            end
            S_WCHK: begin
               if ((cur_ff == '0) || (cur_ff > NodeW'(MaxNodes)) ||
                   (steps_ff >= NodeW'(MaxNodes))) begin
                  res_ff   <= '{32'sd0, NodeW'(0), ERR_WALK};
                  state_ff <= S_OUT;
               end else begin
                  steps_ff <= steps_ff + NodeW'(1);
                  base_ff  <= CoefAw'(CoefAw'(hdr_raddr) * CoefAw'(Slots));
                  state_ff <= S_HDR;
               end
            end
            S_HDR: begin
               hdr_ff <= hdr_rd_ff;
               if (hdr_rd_ff.leaf || cfg.oblique_splits) begin
                  state_ff <= S_BRD;
               end else begin
                  state_ff <= S_SRD0;
               end
            end
            S_BRD: begin
               state_ff <= S_BLD;
            end
            S_BLD: begin
               acc_ff   <= {{32{coef_rd_ff[31]}}, coef_rd_ff};
               j_ff     <= '0;
               state_ff <= S_DRD;
            end
            S_DRD: begin
               state_ff <= S_DMUL;
            end
            S_DMUL: begin
               prod_ff  <= exp_rd_ff * coef_rd_ff;
               state_ff <= S_DACC;
            end
            S_DACC: begin
               acc_ff <= acc_ff + {{(64 - RndW){rnd[RndW-1]}}, rnd};
               j_ff   <= j_ff + FeatAw'(1);
               if (j_ff + FeatAw'(1) == total_ff) begin
                  state_ff <= S_DEND;
               end else begin
                  state_ff <= S_DRD;
               end
            end
            S_DEND: begin
               if (hdr_ff.leaf) begin
                  res_ff   <= '{sat32(acc_ff), cur_ff, ERR_NONE};
                  state_ff <= S_OUT;
               end else begin
                  cur_ff   <= acc_ff[63] ? hdr_ff.child1 : hdr_ff.child0;
                  state_ff <= S_WCHK;
               end
            end
            S_SRD0: begin
               state_ff <= S_SIX;
            end
            S_SIX: begin
               fidx_ff  <= fi_ok ? FeatAw'(quo) : '0;
               state_ff <= S_SRD1;
            end
            S_SRD1: begin
               state_ff <= S_SCMP;
            end
            S_SCMP: begin
               cur_ff   <= (exp_rd_ff >= coef_rd_ff) ? hdr_ff.child0 : hdr_ff.child1;
               state_ff <= S_WCHK;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

### hdl/model_tree_inference_unit.sv
`timescale 1ns / 1ps
// Linear model tree inference. Header and coefficient items load the node
// table. A feature item with last_feature set starts a prediction that
// yields one result: the raw inputs are copied, each polynomial feature
// product is computed, then each visited node forms a weighted sum of the F
// expanded features plus a bias for a leaf or oblique split, or compares one
// feature against a threshold for a single-feature split. The coefficient and
// feature memories each have one read port. A two-entry queue in front holds
// up to two items while a prediction runs, and the result register holds a
// finished result until it is taken.
module model_tree_inference_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mti_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [2:0]       csr_wdata
);
   import mti_pkg::*;

   cfg_type cfg_ff;
   cmd_type q_cmd;
   logic    q_valid;
   logic    q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.oblique_splits <= 1'b0;
         cfg_ff.poly_degree    <= DegW'(1);
         cfg_ff.distinct_only  <= 1'b0;
         cfg_ff.input_count    <= CountW'(4);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_OBLIQUE: cfg_ff.oblique_splits <= csr_wdata[0];
            CSR_DEGREE:  cfg_ff.poly_degree    <= csr_wdata[1:0];
            CSR_INTER:   cfg_ff.distinct_only  <= csr_wdata[0];
            CSR_COUNT:   cfg_ff.input_count    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mti_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_cmd     (q_cmd)
   );

   mti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_cmd     (q_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
   import mti_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_we;
   logic [1:0] csr_index;
   logic [2:0] csr_wdata;

   bit calm;
   int counted_items;

   model_tree_inference_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   class tree_scoreboard;
      bit      oblique;
      int      degree;
      bit      inter;
      int      in_count;
      bit      leaf_of[MaxNodes];
      int      child0_of[MaxNodes];
      int      child1_of[MaxNodes];
      int      coef[MaxNodes * Slots];
      int      raw[MaxInputs];
      int      feat[FeatCap];
      int      received;
      rsp_type pending_rsp[$];
      int      errors;
      int      results_seen;

      function new();
         oblique = 0; degree = 1; inter = 0; in_count = 4;
         received = 0; errors = 0; results_seen = 0;
         foreach (raw[i]) raw[i] = 0;
         foreach (feat[i]) feat[i] = 0;
      endfunction

      function void set_reg(csr_index_type idx, int val);
         case (idx)
            CSR_OBLIQUE: oblique = val[0];
            CSR_DEGREE:  degree = val & 3;
            CSR_INTER:   inter = val[0];
            CSR_COUNT:   in_count = val & 7;
            default: begin
            end
         endcase
      endfunction

      function longint qmul(int a, int b);
         longint p;
         p = longint'(a) * longint'(b);
         return (p + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
      endfunction

      function int clip32(longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return int'(v);
      endfunction

      function longint node_sum(int node, int nf);
         longint acc;
         int base;
         base = (node - 1) * Slots;
         acc = coef[base + nf];
         for (int i = 0; i < nf; i++) acc += qmul(feat[i], coef[base + i]);
         return acc;
      endfunction

      function int expand_features(int n, int deg, bit io);
         int idx[MaxInputs];
         int total, prev_start, prev_len, new_start, new_len, lim, nxt, from;
         total = n; prev_start = 0; prev_len = n;
         for (int i = 0; i < n; i++) begin
            feat[i] = raw[i];
            idx[i] = i;
         end
         for (int d = 1; d < deg; d++) begin
            new_start = total;
            new_len = 0;
            lim = n - (io ? d : 0);
            for (int i = 0; i < lim; i++) begin
               nxt = new_len;
               from = idx[i + (io ? 1 : 0)];
               for (int k = from; k < prev_len && total < FeatCap; k++) begin
                  feat[total] = clip32(qmul(raw[i], feat[prev_start + k]));
                  total++;
                  new_len++;
               end
               idx[i] = nxt;
            end
            prev_start = new_start;
            prev_len = new_len;
         end
         return total;
      endfunction

      function void note(req_type r);
         int      node, deg, nf, cur, steps, base, fv;
         longint  iv, fi;
         bit      side;
         rsp_type e;
         node = r.node_index;
         if (r.kind == KIND_HDR || r.kind == KIND_COEF) begin
            if (node < 1 || node > MaxNodes) return;
            if (r.kind == KIND_HDR) begin
               leaf_of[node - 1] = r.leaf_flag;
               child0_of[node - 1] = r.first_child;
               child1_of[node - 1] = r.second_child;
            end else if (r.coef_slot < Slots) begin
               coef[(node - 1) * Slots + r.coef_slot] = r.coef_value;
            end
            return;
         end
         if (r.kind != KIND_FEAT) return;
         if (received < MaxInputs) raw[received] = r.feature_value;
         if (received < MaxCount) received++;
         if (!r.last_feature) return;
         e.prediction = 0;
         e.leaf_node = '0;
         e.error_code = ERR_NONE;
         if (in_count == 0 || in_count > MaxInputs || received != in_count) begin
            e.error_code = ERR_COUNT;
         end else begin
            deg = (degree < 1) ? 1 : degree;
            if (deg > MaxDegree) deg = MaxDegree;
            if (inter && deg > in_count) deg = in_count;
            nf = expand_features(in_count, deg, inter);
            cur = 1;
            steps = 0;
            while (1) begin
               if (cur < 1 || cur > MaxNodes || steps >= MaxNodes) begin
                  e.error_code = ERR_WALK;
                  break;
               end
               steps++;
               if (leaf_of[cur - 1]) begin
                  e.prediction = clip32(node_sum(cur, nf));
                  e.leaf_node = 7'(cur);
                  break;
               end
               if (oblique) begin
                  side = node_sum(cur, nf) >= 0;
               end else begin
                  base = (cur - 1) * Slots;
                  iv = coef[base];
                  fi = (iv >= 0) ? (iv >>> FracBits) : -((-iv) >>> FracBits);
                  fv = (fi >= 0 && fi < nf) ? feat[fi] : feat[0];
                  side = fv >= coef[base + 1];
               end
               cur = side ? child0_of[cur - 1] : child1_of[cur - 1];
            end
         end
         received = 0;
         pending_rsp = {pending_rsp, e};
      endfunction

      task report(string msg);
         $display("%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check(rsp_type got);
         rsp_type e;
         results_seen++;
         if (pending_rsp.size() == 0) begin
            report("unexpected result");
            return;
         end
         e = pending_rsp.pop_front();
         if (got.prediction !== e.prediction)
            report($sformatf("prediction %h, want %h", got.prediction, e.prediction));
         if (got.leaf_node !== e.leaf_node)
            report($sformatf("leaf_node %0d, want %0d", got.leaf_node, e.leaf_node));
         if (got.error_code !== e.error_code)
            report($sformatf("error_code %0d, want %0d", got.error_code, e.error_code));
      endtask
   endclass

   tree_scoreboard sb = new();

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int rand_q();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 2) == 0 ? 32'sh7fffffff :
                   ($urandom_range(0, 1) ? 32'sh80000000 : 0);
         default: return int'($urandom_range(0, 32'h8ffff)) - 32'sh48000;
      endcase
   endfunction

   function automatic req_type blank_item();
      logic [95:0] b;
      b = {$urandom, $urandom, $urandom};
      return b[94:0];
   endfunction

   task automatic send(req_type r, bit counted);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note(r);
      if (counted) counted_items++;
   endtask

   task automatic send_hdr(int node, bit lf, int c0, int c1, bit counted);
      req_type r;
      r = blank_item();
      r.kind = KIND_HDR;
      r.node_index = 7'(node);
      r.leaf_flag = lf;
      r.first_child = 7'(c0);
      r.second_child = 7'(c1);
      send(r, counted);
   endtask

   task automatic send_coef(int node, int slot, int val, bit counted);
      req_type r;
      r = blank_item();
      r.kind = KIND_COEF;
      r.node_index = 7'(node);
      r.coef_slot = 6'(slot);
      r.coef_value = val;
      send(r, counted);
   endtask

   task automatic predict(int k, int fixed_val, bit use_fixed);
      req_type r;
      for (int i = 0; i < k; i++) begin
         r = blank_item();
         r.kind = KIND_FEAT;
         r.feature_value = use_fixed ? fixed_val : rand_q();
         r.last_feature = (i == k - 1);
         send(r, 1'b1);
      end
   endtask

   function automatic int rand_coef(int slot);
      if (slot == 0 && $urandom_range(0, 1))
         return ((int'($urandom_range(0, 40)) - 3) <<< FracBits) + $urandom_range(0, 16'hffff);
      return rand_q();
   endfunction

   task automatic write_reg(csr_index_type idx, int val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 3'(val);
      sb.set_reg(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic configure(int obl, int deg, int io, int cnt);
      write_reg(CSR_OBLIQUE, obl);
      write_reg(CSR_DEGREE, deg);
      write_reg(CSR_INTER, io);
      write_reg(CSR_COUNT, cnt);
   endtask

   function automatic int rand_child();
      if ($urandom_range(0, 9) > 0) return $urandom_range(1, 8);
      return $urandom_range(0, 3) == 0 ? 0 : $urandom_range(MaxNodes + 1, 127);
   endfunction

   task automatic random_item();
      int r, k;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         if (sb.in_count >= 1 && sb.in_count <= MaxInputs && $urandom_range(0, 9) > 0)
            k = sb.in_count;
         else
            k = $urandom_range(1, 8);
         predict(k, 0, 1'b0);
      end else if (r < 77) begin
         k = $urandom_range(0, Slots - 1);
         send_coef($urandom_range(1, 8), k, rand_coef(k), 1'b1);
      end else if (r < 87) begin
         send_hdr($urandom_range(1, 8), $urandom_range(0, 1), rand_child(), rand_child(), 1'b1);
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               req_type n;
               n = blank_item();
               n.kind = KIND_NONE;
               send(n, 1'b0);
            end
            1: send_hdr($urandom_range(0, 1) ? 0 : $urandom_range(MaxNodes + 1, 127),
                        $urandom_range(0, 1), $urandom_range(0, 127), $urandom_range(0, 127), 1'b0);
            2: send_coef($urandom_range(1, 8), $urandom_range(Slots, 63), $urandom, 1'b0);
            default: send_hdr($urandom_range(9, MaxNodes), $urandom_range(0, 1),
                              $urandom_range(0, 127), $urandom_range(0, 127), 1'b0);
         endcase
      end
   endtask

   initial begin
      int held;
      held = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check(rsp_data);
         if (!reset && sb.results_seen >= 25 && held == 0) begin
            rsp_ready <= 1'b0;
            repeat (600) @(posedge clock);
            held = 1;
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= (calm || pick_gap() == 0);
         end
      end
   end

   initial begin
      #400ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int obl, deg, io, cnt;
      req_type n;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_OBLIQUE;
      csr_wdata <= '0;
      calm = 0;
      counted_items = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      configure(0, 1, 0, 4);

      // tree: 1 -> 2,3; 2 -> 4,5; 3 -> 6,7; 4..8 leaves
      send_hdr(1, 0, 2, 3, 1'b1);
      send_hdr(2, 0, 4, 5, 1'b1);
      send_hdr(3, 0, 6, 7, 1'b1);
      for (int i = 4; i <= 8; i++) send_hdr(i, 1, 1, 1, 1'b1);
      for (int i = 1; i <= 8; i++)
         for (int s = 0; s < Slots; s++) send_coef(i, s, rand_coef(s), 1'b1);

      n = blank_item();
      n.kind = KIND_NONE;
      send(n, 1'b0);
      send_hdr(0, 1, 5, 5, 1'b0);
      send_coef(MaxNodes + 1, 0, 1, 1'b0);
      send_coef(127, 3, 1, 1'b0);
      send_coef(1, 63, 32'sh7fffffff, 1'b0);
      predict(4, 32'sh7fffffff, 1'b1);
      predict(4, 32'sh80000000, 1'b1);
      predict(4, 0, 1'b0);
      predict(3, 0, 1'b0);
      predict(8, 0, 1'b0);
      send_hdr(2, 0, 0, 127, 1'b1);
      predict(4, 0, 1'b0);
      send_hdr(1, 0, 1, 1, 1'b1);
      predict(4, 0, 1'b0);
      send_hdr(1, 0, 2, 3, 1'b1);
      send_hdr(2, 0, 4, 5, 1'b1);
      drain();

      for (int p = 0; counted_items < 850; p++) begin
         calm = (p % 4 == 2);
         case (p)
            0: configure(1, 3, 0, 4);
            1: configure(1, 3, 1, 4);
            2: configure(0, 0, 0, 1);
            3: configure(0, 2, 1, 2);
            4: configure(1, 1, 0, 0);
            5: configure(0, 3, 1, 7);
            6: configure(1, 2, 0, 3);
            default: begin
               obl = $urandom_range(0, 1);
               deg = $urandom_range(0, 3);
               io = $urandom_range(0, 1);
               cnt = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 4);
               configure(obl, deg, io, cnt);
            end
         endcase
         for (int i = 0; i < 50; i++) random_item();
         drain();
      end

      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### model_tree_inference_unit.f
hdl/mti_pkg.sv
hdl/mti_front.sv
hdl/mti_back.sv
hdl/model_tree_inference_unit.sv
verif/tb.sv
